// ===== hw/rtl/dmacc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmacc_pkg
// Types, codes and constants shared by the memory-copy DMA controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dmacc_pkg;

  localparam int ADDR_WIDTH = 32;

  localparam logic [31:0] ADDR_MASK =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_RETURN = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_READ_REF = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [7:0] OFF_SOURCE = 8'h00;
  localparam logic [7:0] OFF_TARGET = 8'h04;
  localparam logic [7:0] OFF_SIZE   = 8'h08;
  localparam logic [7:0] OFF_START  = 8'h0C;

  localparam logic [3:0] SLAVE_LEN  = 4'd4;
  localparam logic [2:0] WORD_BYTES = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  slave_offset;
    logic [3:0]  slave_length;
    logic [31:0] slave_wdata;
    logic [31:0] read_return;
  } in_beat_t;

  typedef struct packed {
    logic        master_valid;
    logic        master_write;
    logic [31:0] master_addr;
    logic [31:0] master_wdata;
    logic [2:0]  master_length;
    logic        interrupt;
    logic [1:0]  slave_status;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dma_copy_controller_top.sv =====
// ----------------------------------------------------------------------------
// dma_copy_controller_top
// Single-channel memory-copy DMA: slave register access plus master access
// sequencing, one beat in and one beat out per event.
//
// Usage:
//   in_*  : one event per beat (tick, slave write, slave read, read data
//           returned), valid/ready handshake.
//   out_* : exactly one result beat per input beat, in order, carrying the
//           master access issued (if any), the interrupt level and the
//           slave status.
//   Path: each beat passes the input register, then the result register,
//   which is loaded with the state update; a beat leaves the input register
//   only while the result register is empty or out_ready is high.
//   Throughput: 1 beat per cycle unless stalled by out_ready; the input
//   register refills in the same cycle its beat moves to the result register.
//   Stall: while out_ready is low and the result register is full, the input
//   register holds one more beat and then in_ready drops.
//   Reset (rst_n low, synchronous): state and valid registers zero (in_r and
//   out_r are not reset), both stages empty, interrupt state low.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_copy_controller_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dmacc_pkg::in_beat_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dmacc_pkg::out_beat_t     out_data
);

  logic                 in_v_r;
  dmacc_pkg::in_beat_t  in_r;
  logic                 out_v_r;
  dmacc_pkg::out_beat_t out_r, out_nxt;
  logic                 adv;

  logic [31:0] src_base_r,   src_base_nxt;
  logic [31:0] dst_base_r,   dst_base_nxt;
  logic [31:0] byte_total_r, byte_total_nxt;
  logic [31:0] go_word_r,    go_word_nxt;
  logic [32:0] byte_count_r, byte_count_nxt;
  logic        write_phase_r, write_phase_nxt;
  logic        awaiting_r,    awaiting_nxt;
  logic [31:0] held_word_r,  held_word_nxt;
  logic        done_r,       done_nxt;

  logic [31:0] src_sum, dst_sum;
  logic [32:0] left;
  logic        more;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign src_sum = src_base_r + byte_count_r[31:0];
  assign dst_sum = dst_base_r + byte_count_r[31:0];
  assign left    = {1'b0, byte_total_r} - byte_count_r;
  assign more    = byte_count_r < {1'b0, byte_total_r};

  always_comb begin
    src_base_nxt    = src_base_r;
    dst_base_nxt    = dst_base_r;
    byte_total_nxt  = byte_total_r;
    go_word_nxt     = go_word_r;
    byte_count_nxt  = byte_count_r;
    write_phase_nxt = write_phase_r;
    awaiting_nxt    = awaiting_r;
    held_word_nxt   = held_word_r;
    done_nxt        = done_r;
    out_nxt         = '0;
    unique case (in_r.action)
      dmacc_pkg::ACT_TICK: begin
        if (go_word_r != 32'd0 && !done_r) begin
          if (more) begin
            if (!write_phase_r) begin
              out_nxt.master_valid  = 1'b1;
              out_nxt.master_addr   = src_sum & dmacc_pkg::ADDR_MASK;
              out_nxt.master_length = dmacc_pkg::WORD_BYTES;
              write_phase_nxt       = 1'b1;
              awaiting_nxt          = 1'b1;
            end else if (!awaiting_r) begin
              out_nxt.master_valid  = 1'b1;
              out_nxt.master_write  = 1'b1;
              out_nxt.master_addr   = dst_sum & dmacc_pkg::ADDR_MASK;
              out_nxt.master_wdata  = held_word_r;
              out_nxt.master_length = (left < 33'd4) ? left[2:0] : dmacc_pkg::WORD_BYTES;
              byte_count_nxt        = byte_count_r + 33'd4;
              write_phase_nxt       = 1'b0;
            end
          end else begin
            go_word_nxt = 32'd0;
            done_nxt    = 1'b1;
          end
        end
      end
      dmacc_pkg::ACT_WRITE: begin
        if (in_r.slave_length != dmacc_pkg::SLAVE_LEN) begin
          out_nxt.slave_status = dmacc_pkg::ST_BAD_LEN;
        end else if (done_r) begin
          if (in_r.slave_offset == dmacc_pkg::OFF_START && in_r.slave_wdata == 32'd0) begin
            src_base_nxt    = '0;
            dst_base_nxt    = '0;
            byte_total_nxt  = '0;
            go_word_nxt     = '0;
            byte_count_nxt  = '0;
            write_phase_nxt = 1'b0;
            awaiting_nxt    = 1'b0;
            held_word_nxt   = '0;
            done_nxt        = 1'b0;
          end else begin
            out_nxt.slave_status = dmacc_pkg::ST_IGNORED;
          end
        end else if (go_word_r != 32'd0) begin
          out_nxt.slave_status = dmacc_pkg::ST_IGNORED;
        end else begin
          unique case (in_r.slave_offset)
            dmacc_pkg::OFF_SOURCE: src_base_nxt   = in_r.slave_wdata;
            dmacc_pkg::OFF_TARGET: dst_base_nxt   = in_r.slave_wdata;
            dmacc_pkg::OFF_SIZE:   byte_total_nxt = in_r.slave_wdata;
            dmacc_pkg::OFF_START:  go_word_nxt    = in_r.slave_wdata;
            default:               out_nxt.slave_status = dmacc_pkg::ST_IGNORED;
          endcase
        end
      end
      dmacc_pkg::ACT_READ: begin
        out_nxt.slave_status = dmacc_pkg::ST_READ_REF;
      end
      dmacc_pkg::ACT_RETURN: begin
        if (awaiting_r) begin
          held_word_nxt = in_r.read_return;
          awaiting_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
    out_nxt.interrupt = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      src_base_r    <= '0;
      dst_base_r    <= '0;
      byte_total_r  <= '0;
      go_word_r     <= '0;
      byte_count_r  <= '0;
      write_phase_r <= 1'b0;
      awaiting_r    <= 1'b0;
      held_word_r   <= '0;
      done_r        <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r       <= 1'b1;
        src_base_r    <= src_base_nxt;
        dst_base_r    <= dst_base_nxt;
        byte_total_r  <= byte_total_nxt;
        go_word_r     <= go_word_nxt;
        byte_count_r  <= byte_count_nxt;
        write_phase_r <= write_phase_nxt;
        awaiting_r    <= awaiting_nxt;
        held_word_r   <= held_word_nxt;
        done_r        <= done_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // checks
  a_await_in_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> write_phase_r) else $error("read outstanding outside write phase");

  a_done_clears_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (go_word_r == 32'd0)) else $error("start set while done");

  a_count_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r[1:0] == 2'b00) else $error("byte count not word aligned");

  a_access_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.master_valid) |-> (out_r.master_length != 3'd0))
    else $error("master access with zero length");

  a_write_is_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.master_write) |-> out_r.master_valid)
    else $error("master write without access");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the memory-copy DMA controller. A queue of events
// (ticks, slave accesses, returned read data) feeds a handshake driver. Each
// accepted beat runs through a local copy-engine predictor. A monitor compares
// every result beat, field by field, against the oldest predicted result.
// Stimulus is a short directed part, then random copy jobs with noise mixed in.
// ----------------------------------------------------------------------------

module tb;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 out_ready = 1'b0;
  dmacc_pkg::in_beat_t  in_data   = '0;
  logic                 in_ready;
  logic                 out_valid;
  dmacc_pkg::out_beat_t out_data;

  dmacc_pkg::in_beat_t  pending_ops[$];
  dmacc_pkg::out_beat_t predicted_outs[$];
  int        send_gap      = 0;
  int        stall_left    = 0;
  int        mismatch_count = 0;
  logic      tail_phase    = 1'b0;

  // predictor state
  logic [31:0] src_addr_q;
  logic [31:0] dst_addr_q;
  logic [31:0] copy_len_q;
  logic [31:0] start_word_q;
  logic [32:0] copied_bytes_q;
  logic        write_next_q;
  logic        read_pending_q;
  logic [31:0] buffer_word_q;
  logic        done_q;

  dma_copy_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_copy_state();
    src_addr_q     = '0;
    dst_addr_q     = '0;
    copy_len_q     = '0;
    start_word_q   = '0;
    copied_bytes_q = '0;
    write_next_q   = 1'b0;
    read_pending_q = 1'b0;
    buffer_word_q  = '0;
    done_q         = 1'b0;
  endfunction

  function automatic dmacc_pkg::out_beat_t next_bus_result(dmacc_pkg::in_beat_t b);
    dmacc_pkg::out_beat_t r;
    logic [32:0]          left;
    r = '0;
    case (b.action)
      dmacc_pkg::ACT_TICK: begin
        if (start_word_q != 0 && !done_q) begin
          if (copied_bytes_q < {1'b0, copy_len_q}) begin
            if (!write_next_q) begin
              r.master_valid  = 1'b1;
              r.master_addr   = (src_addr_q + copied_bytes_q[31:0]) & dmacc_pkg::ADDR_MASK;
              r.master_length = dmacc_pkg::WORD_BYTES;
              write_next_q    = 1'b1;
              read_pending_q  = 1'b1;
            end else if (!read_pending_q) begin
              left            = {1'b0, copy_len_q} - copied_bytes_q;
              r.master_valid  = 1'b1;
              r.master_write  = 1'b1;
              r.master_addr   = (dst_addr_q + copied_bytes_q[31:0]) & dmacc_pkg::ADDR_MASK;
              r.master_wdata  = buffer_word_q;
              r.master_length = (left < 33'(dmacc_pkg::WORD_BYTES)) ? left[2:0]
                                                                     : dmacc_pkg::WORD_BYTES;
              copied_bytes_q  = copied_bytes_q + 33'(dmacc_pkg::WORD_BYTES);
              write_next_q    = 1'b0;
            end
          end else begin
            start_word_q = '0;
            done_q       = 1'b1;
          end
        end
      end
      dmacc_pkg::ACT_WRITE: begin
        if (b.slave_length != dmacc_pkg::SLAVE_LEN) begin
          r.slave_status = dmacc_pkg::ST_BAD_LEN;
        end else if (done_q) begin
          if (b.slave_offset == dmacc_pkg::OFF_START && b.slave_wdata == 0) clear_copy_state();
          else r.slave_status = dmacc_pkg::ST_IGNORED;
        end else if (start_word_q != 0) begin
          r.slave_status = dmacc_pkg::ST_IGNORED;
        end else begin
          case (b.slave_offset)
            dmacc_pkg::OFF_SOURCE: src_addr_q   = b.slave_wdata;
            dmacc_pkg::OFF_TARGET: dst_addr_q   = b.slave_wdata;
            dmacc_pkg::OFF_SIZE:   copy_len_q   = b.slave_wdata;
            dmacc_pkg::OFF_START:  start_word_q = b.slave_wdata;
            default:               r.slave_status = dmacc_pkg::ST_IGNORED;
          endcase
        end
      end
      dmacc_pkg::ACT_READ: r.slave_status = dmacc_pkg::ST_READ_REF;
      default: begin
        if (read_pending_q) begin
          buffer_word_q  = b.read_return;
          read_pending_q = 1'b0;
        end
      end
    endcase
    r.interrupt = done_q;
    return r;
  endfunction

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      clear_copy_state();
    end else begin
      tail_phase <= (pending_ops.size() < 80);
      if (in_valid && in_ready) predicted_outs.push_back(next_bus_result(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          if (!tail_phase && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 2);
            in_valid <= 1'b0;
          end else begin
            in_data  <= pending_ops.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outs.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatch_count++;
        end else begin
          dmacc_pkg::out_beat_t want;
          want = predicted_outs.pop_front();
          flag_field("master_valid",  want.master_valid,  out_data.master_valid);
          flag_field("master_write",  want.master_write,  out_data.master_write);
          flag_field("master_addr",   want.master_addr,   out_data.master_addr);
          flag_field("master_wdata",  want.master_wdata,  out_data.master_wdata);
          flag_field("master_length", want.master_length, out_data.master_length);
          flag_field("interrupt",     want.interrupt,     out_data.interrupt);
          flag_field("slave_status",  want.slave_status,  out_data.slave_status);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_op(logic [1:0] act, logic [7:0] off, logic [3:0] len,
                         logic [31:0] wd, logic [31:0] rd);
    dmacc_pkg::in_beat_t b;
    b.action       = act;
    b.slave_offset = off;
    b.slave_length = len;
    b.slave_wdata  = wd;
    b.read_return  = rd;
    pending_ops.push_back(b);
  endtask

  task automatic push_tick();
    push_op(dmacc_pkg::ACT_TICK, 8'($urandom), 4'($urandom_range(0, 8)), $urandom, $urandom);
  endtask

  task automatic push_write(logic [7:0] off, logic [31:0] data);
    push_op(dmacc_pkg::ACT_WRITE, off, dmacc_pkg::SLAVE_LEN, data, $urandom);
  endtask

  task automatic push_return(logic [31:0] data);
    push_op(dmacc_pkg::ACT_RETURN, 8'($urandom), 4'($urandom_range(0, 8)), $urandom, data);
  endtask

  task automatic push_noise();
    push_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
            4'($urandom_range(0, 8)), $urandom, $urandom);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) push_noise();
  endtask

  function automatic logic [31:0] pick_base();
    if ($urandom_range(0, 7) == 0) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    return $urandom;
  endfunction

  task automatic push_copy_job();
    int unsigned len_bytes;
    int unsigned words;
    logic [31:0] go;
    len_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                            : $urandom_range(0, 24);
    words = (len_bytes + 3) / 4;
    go = $urandom;
    if (go == 0) go = 32'd1;
    push_write(dmacc_pkg::OFF_SOURCE, pick_base());
    maybe_noise();
    push_write(dmacc_pkg::OFF_TARGET, pick_base());
    maybe_noise();
    push_write(dmacc_pkg::OFF_SIZE, len_bytes);
    push_write(dmacc_pkg::OFF_START, go);
    for (int w = 0; w < words; w++) begin
      push_tick();
      maybe_noise();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_tick();
      if ($urandom_range(0, 19) != 0) push_return($urandom);
      maybe_noise();
      push_tick();
    end
    push_tick();
    if ($urandom_range(0, 3) == 0) push_tick();
    if ($urandom_range(0, 7) == 0) push_write(dmacc_pkg::OFF_START, $urandom | 32'd1);
    if ($urandom_range(0, 9) != 0) push_write(dmacc_pkg::OFF_START, 32'd0);
  endtask

  initial begin
    // directed: idle events, refused accesses, wrapping 5-byte copy, zero size
    push_tick();
    push_op(dmacc_pkg::ACT_READ, 8'($urandom), dmacc_pkg::SLAVE_LEN, $urandom, $urandom);
    push_op(dmacc_pkg::ACT_WRITE, dmacc_pkg::OFF_SOURCE, 4'd8, 32'hFFFF_FFFF, 32'h0);
    push_op(dmacc_pkg::ACT_WRITE, dmacc_pkg::OFF_START, 4'd0, 32'h1, 32'h0);
    push_write(8'hFF, 32'hFFFF_FFFF);
    push_return(32'hFFFF_FFFF);
    push_write(dmacc_pkg::OFF_SOURCE, 32'hFFFF_FFFE);
    push_write(dmacc_pkg::OFF_TARGET, 32'hFFFF_FFFF);
    push_write(dmacc_pkg::OFF_SIZE, 32'hFFFF_FFFF);
    push_write(dmacc_pkg::OFF_SIZE, 32'd5);
    push_write(dmacc_pkg::OFF_START, 32'hFFFF_FFFF);
    push_tick();
    push_tick();
    push_return(32'hA5A5_5A5A);
    push_tick();
    push_write(dmacc_pkg::OFF_SIZE, 32'd0);
    push_tick();
    push_return(32'h0000_0001);
    push_tick();
    push_tick();
    push_write(dmacc_pkg::OFF_START, 32'd1);
    push_write(dmacc_pkg::OFF_START, 32'd0);
    push_write(dmacc_pkg::OFF_START, 32'd1);
    push_tick();
    push_write(dmacc_pkg::OFF_START, 32'd0);

    while (pending_ops.size() < 730) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) push_noise();
      else push_copy_job();
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || in_valid || predicted_outs.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
